// ===== rtl/dsn_pkg.sv =====
// Package for the Newton square root block: binary64 field constants and codes.
// Used by the controller, the datapath and the top level. No dependencies.
package dsn_pkg;

	localparam int ITERATION_LIMIT_DEFAULT = 20;
	localparam logic [63:0] QNAN_BITS  = 64'h7FF8000000000000;
	localparam logic [63:0] ONE_BITS   = 64'h3FF0000000000000;
	localparam logic [63:0] EXP_FIELD  = 64'h7FF0000000000000;
	localparam logic [63:0] FRAC_FIELD = 64'h000FFFFFFFFFFFFF;
	localparam logic [63:0] MAG_MASK   = 64'h7FFFFFFFFFFFFFFF;

	// Datapath commands.
	localparam logic [2:0] CMD_NONE  = 3'd0;
	localparam logic [2:0] CMD_LOAD  = 3'd1;
	localparam logic [2:0] CMD_DIV   = 3'd2;
	localparam logic [2:0] CMD_DSTEP = 3'd3;
	localparam logic [2:0] CMD_DFIN  = 3'd4;
	localparam logic [2:0] CMD_ADD   = 3'd5;

	typedef struct packed {
		logic [2:0] op;
	} dsn_cmd_t;

	typedef struct packed {
		logic special;   // result already final after load
		logic div_done;  // quotient bits all produced
		logic same;      // last update left the guess unchanged
	} dsn_stat_t;

endpackage

// ===== rtl/dsn_ctrl.sv =====
// Controller for the Newton square root block: sequences load, divide,
// add/halve and the stop tests. Depends on dsn_pkg.
module dsn_ctrl #(
	parameter int ITERATION_LIMIT = dsn_pkg::ITERATION_LIMIT_DEFAULT
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_fire,
	input  logic               out_free,
	input  dsn_pkg::dsn_stat_t stat,
	output dsn_pkg::dsn_cmd_t  cmd,
	output logic               busy,
	output logic               done
);

	localparam int CW = $clog2(ITERATION_LIMIT + 1);
	localparam logic [2:0] S_IDLE = 3'd0;
	localparam logic [2:0] S_CHK  = 3'd1;
	localparam logic [2:0] S_DIV  = 3'd2;
	localparam logic [2:0] S_DFIN = 3'd3;
	localparam logic [2:0] S_ADD  = 3'd4;
	localparam logic [2:0] S_TEST = 3'd5;
	localparam logic [2:0] S_OUT  = 3'd6;

	logic [2:0]    state_q;
	logic [CW-1:0] iter_q;

	// State register and update counter.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			iter_q  <= '0;
		end else begin
			case (state_q)
				S_IDLE: begin
					if (in_fire) begin
						state_q <= S_CHK;
						iter_q  <= '0;
					end
				end
				S_CHK:  state_q <= stat.special ? S_OUT : S_DIV;
				S_DIV:  if (stat.div_done) state_q <= S_DFIN;
				S_DFIN: state_q <= S_ADD;
				S_ADD: begin
					state_q <= S_TEST;
					iter_q  <= iter_q + 1'b1;
				end
				S_TEST: begin
					if (stat.same || iter_q == CW'(ITERATION_LIMIT)) state_q <= S_OUT;
					else state_q <= S_DIV;
				end
				S_OUT:  if (out_free) state_q <= S_IDLE;
				default: state_q <= S_IDLE;
			endcase
		end
	end

	// Command decode.
	always_comb begin
		case (state_q)
			S_IDLE:  cmd.op = in_fire ? dsn_pkg::CMD_LOAD : dsn_pkg::CMD_NONE;
			S_DIV:   cmd.op = dsn_pkg::CMD_DSTEP;
			S_DFIN:  cmd.op = dsn_pkg::CMD_DFIN;
			S_ADD:   cmd.op = dsn_pkg::CMD_ADD;
			S_TEST:  cmd.op = (stat.same || iter_q == CW'(ITERATION_LIMIT)) ?
			                  dsn_pkg::CMD_NONE : dsn_pkg::CMD_DIV;
			S_CHK:   cmd.op = stat.special ? dsn_pkg::CMD_NONE : dsn_pkg::CMD_DIV;
			default: cmd.op = dsn_pkg::CMD_NONE;
		endcase
	end

	assign busy = (state_q != S_IDLE);
	assign done = (state_q == S_OUT);

endmodule

// ===== rtl/dsn_dp.sv =====
// Datapath for the Newton square root block: operand registers, a radix-2
// mantissa divider and a round-to-nearest-even adder with halving.
// Depends on dsn_pkg.
module dsn_dp (
	input  logic               clk,
	input  logic [63:0]        operand_bits,
	input  dsn_pkg::dsn_cmd_t  cmd,
	output dsn_pkg::dsn_stat_t stat,
	output logic [63:0]        root_bits
);

	// Operand x is positive, finite and nonzero on the iterative path, as is guess.
	logic [63:0] x_q, g_q, res_q, q_q;
	logic        special_q, same_q;
	// Divider state: quotient bits, remainder, step count.
	logic [55:0] quo_q;
	logic [54:0] rem_q;
	logic [53:0] dvs_q;
	logic [6:0]  dstep_q;
	logic signed [12:0] qexp_q;

	// Unpack helpers: biased exponent (normalized for a subnormal x) and mantissa with hidden bit.
	logic [10:0] xe, ge;
	logic [52:0] xm, gm;
	logic [5:0]  xlz;
	logic [52:0] xmn;
	logic signed [12:0] xen;
	always_comb begin
		xe = x_q[62:52];
		ge = g_q[62:52];
		xm = {xe != 11'd0, x_q[51:0]};
		gm = {1'b1, g_q[51:0]};
		xlz = 6'd0;
		for (int i = 52; i >= 0; i--) begin
			if (xm[i] && xlz == 6'd0 && i != 52) xlz = 6'(52 - i);
			if (xm[52]) xlz = 6'd0;
		end
		xmn = xm << xlz;
		xen = (xe == 11'd0) ? 13'sd1 - $signed({7'd0, xlz}) : $signed({2'd0, xe});
	end

	// Quotient rounding: q has 56 bits with leading bit at 55 or 54.
	logic [55:0] qn;
	logic signed [12:0] qe;
	logic [52:0] qm;
	logic        qr, qs, qup;
	logic [53:0] qmr;
	logic [63:0] qbits;
	always_comb begin
		if (quo_q[55]) begin
			qn = quo_q; qe = qexp_q;
		end else begin
			qn = quo_q << 1; qe = qexp_q - 13'sd1;
		end
		qm  = qn[55:3];
		qr  = qn[2];
		qs  = qn[1] | qn[0] | (rem_q != 55'd0);
		qup = qr & (qs | qm[0]);
		qmr = {1'b0, qm} + {53'd0, qup};
		if (qmr[53]) qe = qe + 13'sd1;
		// A quotient below the normal range only comes from a subnormal operand.
		// It is then far below half an ulp of the guess, so flushing it to zero
		// leaves the rounded sum unchanged.
		if (qe <= 13'sd0) begin
			qbits = 64'd0;
		end else begin
			qbits = {1'b0, qe[10:0], qmr[53] ? qmr[52:1] : qmr[51:0]};
		end
	end

	// Sum g + q then halve; g is positive and normal, q is positive and normal or flushed to zero.
	logic [63:0] big, sml;
	logic [10:0] eb, es, ediff;
	logic [55:0] mb, ms, msh;
	logic        stk;
	logic [56:0] msum;
	logic [55:0] mn;
	logic signed [12:0] se;
	logic [52:0] sm;
	logic        sr, ss, sup;
	logic [53:0] smr;
	logic [63:0] sbits;
	always_comb begin
		if (g_q[62:0] >= q_q[62:0]) begin
			big = g_q; sml = q_q;
		end else begin
			big = q_q; sml = g_q;
		end
		eb = big[62:52];
		es = sml[62:52];
		ediff = eb - es;
		mb = {1'b1, big[51:0], 3'd0};
		ms = {es != 11'd0, sml[51:0], 3'd0};
		stk = 1'b0;
		if (ediff > 11'd56) begin
			msh = 56'd0; stk = (ms != 56'd0);
		end else begin
			msh = ms >> ediff;
			stk = ((msh << ediff) != ms);
		end
		msum = {1'b0, mb} + {1'b0, msh};
		if (msum[56]) begin
			mn = msum[56:1]; stk = stk | msum[0]; se = $signed({2'd0, eb});
		end else begin
			mn = msum[55:0]; se = $signed({2'd0, eb}) - 13'sd1;
		end
		sm  = mn[55:3];
		sr  = mn[2];
		ss  = mn[1] | mn[0] | stk;
		sup = sr & (ss | sm[0]);
		smr = {1'b0, sm} + {53'd0, sup};
		if (smr[53]) se = se + 13'sd1;
		// se already includes the halving (sum exponent eb+1 minus one).
		if (se >= 13'sd2047) sbits = 64'h7FF0000000000000;
		else sbits = {1'b0, se[10:0], smr[53] ? smr[52:1] : smr[51:0]};
	end

	// Special operand decode at load.
	logic [63:0] mag;
	logic        is_nan;
	assign mag    = operand_bits & dsn_pkg::MAG_MASK;
	assign is_nan = ((mag & dsn_pkg::EXP_FIELD) == dsn_pkg::EXP_FIELD) &&
	                ((mag & dsn_pkg::FRAC_FIELD) != 64'd0);

	logic [54:0] rtry;
	assign rtry = rem_q - {1'b0, dvs_q};

	// Register updates under command.
	always_ff @(posedge clk) begin
		case (cmd.op)
			dsn_pkg::CMD_LOAD: begin
				x_q       <= operand_bits;
				special_q <= 1'b1;
				same_q    <= 1'b0;
				if (is_nan) res_q <= dsn_pkg::QNAN_BITS;
				else if (mag == 64'd0) res_q <= operand_bits;
				else if (operand_bits[63]) res_q <= dsn_pkg::QNAN_BITS;
				else if (mag == dsn_pkg::EXP_FIELD) res_q <= operand_bits;
				else begin
					special_q <= 1'b0;
					g_q <= (operand_bits[62:0] > dsn_pkg::ONE_BITS[62:0]) ?
					       operand_bits : dsn_pkg::ONE_BITS;
				end
			end
			dsn_pkg::CMD_DIV: begin
				rem_q   <= {2'b0, xmn};
				dvs_q   <= {1'b0, gm};
				quo_q   <= 56'd0;
				dstep_q <= 7'd0;
				qexp_q  <= xen - $signed({2'd0, ge}) + 13'sd1023;
			end
			dsn_pkg::CMD_DSTEP: begin
				if (!rtry[54]) begin
					rem_q <= {rtry[53:0], 1'b0};
					quo_q <= {quo_q[54:0], 1'b1};
				end else begin
					rem_q <= {rem_q[53:0], 1'b0};
					quo_q <= {quo_q[54:0], 1'b0};
				end
				dstep_q <= dstep_q + 7'd1;
			end
			dsn_pkg::CMD_DFIN: q_q <= qbits;
			dsn_pkg::CMD_ADD: begin
				same_q <= (sbits == g_q);
				g_q    <= sbits;
				res_q  <= sbits;
			end
			default: ;
		endcase
	end

	assign stat.special  = special_q;
	assign stat.div_done = (dstep_q == 7'd55);
	assign stat.same     = same_q;
	assign root_bits     = res_q;

endmodule

// ===== rtl/double_sqrt_newton.sv =====
// Top level of the Newton square root block for binary64 operands.
// Instantiates dsn_ctrl and dsn_dp; uses dsn_pkg.
//
// One request in, one result out. A special operand goes from the load and
// check straight to the output. Others run N updates, N at most
// ITERATION_LIMIT; each update is the one-bit-per-cycle mantissa divider,
// then quotient rounding, add/halve and the stop test. One request is
// worked on at a time; a finished result moves to an output register, so
// the next request can be accepted while that result waits to be taken.
module double_sqrt_newton #(
	parameter int ITERATION_LIMIT = dsn_pkg::ITERATION_LIMIT_DEFAULT
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [63:0] s_tdata,   // [63:0] operand_bits
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [63:0] m_tdata    // [63:0] root_bits
);

	dsn_pkg::dsn_cmd_t  cmd;
	dsn_pkg::dsn_stat_t stat;
	logic        busy, done;
	logic [63:0] root_bits;
	logic        out_free;
	logic        out_valid_q;
	logic [63:0] out_data_q;

	assign s_tready = !busy;
	assign out_free = !out_valid_q || m_tready;

	// Output register: takes a finished result whenever it is empty or being read.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
			out_data_q  <= '0;
		end else if (done && out_free) begin
			out_valid_q <= 1'b1;
			out_data_q  <= root_bits;
		end else if (m_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tdata  = out_data_q;

	dsn_ctrl #(.ITERATION_LIMIT(ITERATION_LIMIT)) u_ctrl (
		.clk(clk), .arst_n(arst_n),
		.in_fire(s_tvalid && !busy), .out_free(out_free),
		.stat(stat), .cmd(cmd), .busy(busy), .done(done)
	);

	dsn_dp u_dp (
		.clk(clk), .operand_bits(s_tdata), .cmd(cmd), .stat(stat), .root_bits(root_bits)
	);

endmodule
